// ===== rtl/least_loaded_task_dispatcher_defines.svh =====
// Assertion macros shared by the dispatcher RTL.
// No dependencies.
`ifndef LEAST_LOADED_TASK_DISPATCHER_DEFINES_SVH
`define LEAST_LOADED_TASK_DISPATCHER_DEFINES_SVH
`ifndef SYNTH
`define LLTD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LLTD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLTD_ASSERT(label, clk, rst_n, prop, msg)
`define LLTD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/lltd_pkg.sv =====
// Types and constants for the least-loaded task dispatcher.
// No dependencies.
package lltd_pkg;
    localparam int CpuW = 4;
    localparam int TaskW = 10;
    localparam int CountW = 11;
    localparam int SliceW = 8;

    typedef enum logic [1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_BALANCE = 2'd1,
        MODE_TICK = 2'd2,
        MODE_BAD = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_QUEUED = 3'd0,
        ST_NO_MIGRATE = 3'd1,
        ST_MIGRATED = 3'd2,
        ST_RUNNING = 3'd3,
        ST_IDLE = 3'd4,
        ST_BAD_CPU = 3'd5
    } status_t;

    localparam logic CFG_ACTIVE_CPUS = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [TaskW-1:0] task_id;
        logic [SliceW-1:0] budget_slices;
        logic [CpuW-1:0] cpu_select;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [CpuW-1:0] cpu_first;
        logic [CpuW-1:0] cpu_second;
        logic [TaskW-1:0] moved_task;
        logic finish_flag;
        logic [TaskW-1:0] finished_task;
    } rsp_t;
endpackage

// ===== rtl/lltd_stream_if.sv =====
// Valid/ready channel carrying one payload of type T.
// No dependencies; the payload type is the parameter T.
interface lltd_stream_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lltd_scan.sv =====
// Sequential min/max scan over the per-CPU list counts, one CPU per cycle.
// Depends on lltd_pkg.
module lltd_scan #(
    parameter int CPU_COUNT = 16
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic [$clog2(CPU_COUNT+1)-1:0] n_cpus,
    input logic [lltd_pkg::CountW-1:0] counts [CPU_COUNT],
    output logic done,
    output logic [$clog2(CPU_COUNT)-1:0] hi_idx,
    output logic [$clog2(CPU_COUNT)-1:0] lo_idx
);
    import lltd_pkg::*;
    localparam int IW = $clog2(CPU_COUNT);
    localparam int NW = $clog2(CPU_COUNT+1);

    logic busy_reg, busy_next;
    logic [NW-1:0] i_reg, i_next;
    logic [IW-1:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [CountW-1:0] cur;

    assign cur = counts[i_reg[IW-1:0]];

    always_comb
    begin
        busy_next = busy_reg;
        i_next = i_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next = NW'(1);
            hi_next = '0;
            lo_next = '0;
        end
        else if (busy_reg)
        begin
            if (i_reg >= n_cpus)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (cur > counts[hi_reg]) hi_next = i_reg[IW-1:0];
                if (cur < counts[lo_reg]) lo_next = i_reg[IW-1:0];
                i_next = i_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg <= i_next;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done = busy_reg && (i_reg >= n_cpus);
    assign hi_idx = hi_reg;
    assign lo_idx = lo_reg;
endmodule

// ===== rtl/least_loaded_task_dispatcher.sv =====
// Least-loaded task dispatcher: submit, balance and tick on per-CPU LIFO lists.
// Submit and balance wait for the count scan, which visits one CPU per cycle;
// a tick first reads the running task's budget and used slices from memory.
// One request at a time; in_req.ready is low until the result leaves and rises
// in the cycle after it leaves. Reset clears counts and running flags.
// Depends on lltd_pkg, lltd_stream_if, lltd_scan and the defines header.
`include "least_loaded_task_dispatcher_defines.svh"
module least_loaded_task_dispatcher #(
    parameter int CPU_COUNT = 16,
    parameter int TASK_SLOTS = 1024
) (
    input logic clk,
    input logic rst_n,
    lltd_stream_if.sink in_req,
    lltd_stream_if.source out_rsp,
    input logic cfg_we,
    input logic cfg_index,
    input logic [4:0] cfg_data
);
    import lltd_pkg::*;
    localparam int IW = $clog2(CPU_COUNT);
    localparam int NW = $clog2(CPU_COUNT+1);
    localparam int SW = $clog2(TASK_SLOTS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SCAN = 8'b00000010,
        S_RD   = 8'b00000100,
        S_RDW  = 8'b00001000,
        S_POP  = 8'b00010000,
        S_TICK = 8'b00100000,
        S_PUSH = 8'b01000000,
        S_OUT  = 8'b10000000
    } state_t;

    state_t state_reg;
    req_t req_reg;
    rsp_t rsp_reg;
    rsp_t idle_rsp;
    logic tick_bad;
    logic [4:0] active_reg;
    logic [3:0] thr_reg;
    logic [CountW-1:0] count_reg [CPU_COUNT];
    logic [TaskW-1:0] head_reg [CPU_COUNT];
    logic [TaskW-1:0] run_task_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0] run_valid_reg;
    logic [TaskW-1:0] link_mem [TASK_SLOTS];
    logic [SliceW-1:0] budget_mem [TASK_SLOTS];
    logic [SliceW-1:0] used_mem [TASK_SLOTS];
    logic [TaskW-1:0] link_q_reg;
    logic [SliceW-1:0] budget_q_reg, used_q_reg;
    logic [SW-1:0] rd_addr_reg;
    logic [TaskW-1:0] task_reg;
    logic [IW-1:0] hi_reg, lo_reg;
    logic [NW-1:0] n_eff;
    logic scan_start, scan_done;
    logic [IW-1:0] scan_hi, scan_lo;
    logic [IW-1:0] sel;
    logic [CountW-1:0] d;

    assign n_eff = (active_reg == 5'd0) ? NW'(1)
        : (32'(active_reg) > CPU_COUNT) ? NW'(CPU_COUNT) : NW'(active_reg);
    assign sel = req_reg.cpu_select[IW-1:0];
    assign scan_start = in_req.valid && in_req.ready
        && (in_req.data.mode == MODE_SUBMIT || in_req.data.mode == MODE_BALANCE);
    assign d = count_reg[hi_reg] - count_reg[lo_reg];
    assign tick_bad = ({1'b0, in_req.data.cpu_select} >= 5'(n_eff));

    always_comb
    begin
        idle_rsp = '0;
        if (in_req.data.mode == MODE_TICK)
        begin
            idle_rsp.cpu_first = in_req.data.cpu_select;
            if (tick_bad) idle_rsp.status = ST_BAD_CPU;
        end
        else if (in_req.data.mode == MODE_BAD)
        begin
            idle_rsp.status = ST_BAD_CPU;
        end
    end

    lltd_scan #(.CPU_COUNT(CPU_COUNT)) u_scan (
        .clk(clk), .rst_n(rst_n), .start(scan_start), .n_cpus(n_eff),
        .counts(count_reg), .done(scan_done), .hi_idx(scan_hi), .lo_idx(scan_lo)
    );

    assign in_req.ready = (state_reg == S_IDLE);
    assign out_rsp.valid = (state_reg == S_OUT);
    assign out_rsp.data = rsp_reg;

    always_ff @(posedge clk)
    begin
        link_q_reg <= link_mem[rd_addr_reg];
        budget_q_reg <= budget_mem[rd_addr_reg];
        used_q_reg <= used_mem[rd_addr_reg];
        if (state_reg == S_IDLE && in_req.valid && in_req.data.mode == MODE_SUBMIT)
        begin
            budget_mem[in_req.data.task_id[SW-1:0]] <= in_req.data.budget_slices;
            used_mem[in_req.data.task_id[SW-1:0]] <= '0;
        end
        else if (state_reg == S_TICK && used_q_reg != 8'hFF)
        begin
            used_mem[rd_addr_reg] <= used_q_reg + 8'd1;
        end
        if (state_reg == S_PUSH)
        begin
            link_mem[task_reg[SW-1:0]] <= head_reg[lo_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            active_reg <= 5'd8;
            thr_reg <= 4'd1;
            run_valid_reg <= '0;
            for (int c = 0; c < CPU_COUNT; c++) count_reg[c] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ACTIVE_CPUS) active_reg <= cfg_data;
                else thr_reg <= cfg_data[3:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_req.valid)
                    begin
                        req_reg <= in_req.data;
                        rsp_reg <= idle_rsp;
                        unique case (in_req.data.mode) inside
                            MODE_SUBMIT, MODE_BALANCE:
                            begin
                                task_reg <= in_req.data.task_id;
                                state_reg <= S_SCAN;
                            end
                            MODE_TICK:
                            begin
                                if (tick_bad)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else if (run_valid_reg[in_req.data.cpu_select[IW-1:0]])
                                begin
                                    rd_addr_reg <= run_task_reg[
                                        in_req.data.cpu_select[IW-1:0]][SW-1:0];
                                    task_reg <= run_task_reg[
                                        in_req.data.cpu_select[IW-1:0]];
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    hi_reg <= in_req.data.cpu_select[IW-1:0];
                                    lo_reg <= in_req.data.cpu_select[IW-1:0];
                                    state_reg <= S_POP;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        hi_reg <= scan_hi;
                        lo_reg <= scan_lo;
                        if (req_reg.mode == MODE_SUBMIT)
                        begin
                            rsp_reg.status <= ST_QUEUED;
                            rsp_reg.cpu_first <= CpuW'(scan_lo);
                            state_reg <= S_PUSH;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                end
                S_RD: state_reg <= S_RDW;
                S_RDW:
                begin
                    // After the link read of the head, a pop retires it.
                    if (req_reg.mode != MODE_TICK)
                    begin
                        head_reg[hi_reg] <= link_q_reg;
                        count_reg[hi_reg] <= count_reg[hi_reg] - 1'b1;
                    end
                    if (req_reg.mode == MODE_BAD)
                    begin
                        req_reg.mode <= MODE_BALANCE;
                        state_reg <= S_PUSH;
                    end
                    else if (req_reg.mode == MODE_SUBMIT)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_TICK;
                    end
                end
                S_TICK:
                begin
                    run_valid_reg[sel] <= 1'b0;
                    hi_reg <= sel;
                    lo_reg <= sel;
                    if (((used_q_reg == 8'hFF) ? used_q_reg : used_q_reg + 8'd1)
                        >= budget_q_reg)
                    begin
                        rsp_reg.finish_flag <= 1'b1;
                        rsp_reg.finished_task <= task_reg;
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_POP:
                begin
                    if (req_reg.mode == MODE_BALANCE)
                    begin
                        if (d > CountW'(thr_reg))
                        begin
                            task_reg <= head_reg[hi_reg];
                            rd_addr_reg <= head_reg[hi_reg][SW-1:0];
                            rsp_reg.status <= ST_MIGRATED;
                            rsp_reg.cpu_first <= CpuW'(hi_reg);
                            rsp_reg.cpu_second <= CpuW'(lo_reg);
                            rsp_reg.moved_task <= head_reg[hi_reg];
                            state_reg <= S_RD;
                            req_reg.mode <= MODE_BAD;
                        end
                        else
                        begin
                            rsp_reg.status <= ST_NO_MIGRATE;
                            state_reg <= S_OUT;
                        end
                    end
                    else if (count_reg[hi_reg] != '0)
                    begin
                        rd_addr_reg <= head_reg[hi_reg][SW-1:0];
                        run_task_reg[hi_reg] <= head_reg[hi_reg];
                        run_valid_reg[hi_reg] <= 1'b1;
                        rsp_reg.status <= ST_RUNNING;
                        rsp_reg.moved_task <= head_reg[hi_reg];
                        req_reg.mode <= MODE_SUBMIT;
                        task_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        rsp_reg.status <= ST_IDLE;
                        state_reg <= S_OUT;
                    end
                end
                S_PUSH:
                begin
                    head_reg[lo_reg] <= task_reg;
                    if (count_reg[lo_reg] != '1) count_reg[lo_reg] <= count_reg[lo_reg] + 1'b1;
                    state_reg <= (req_reg.mode == MODE_TICK) ? S_POP : S_OUT;
                end
                S_OUT:
                begin
                    if (out_rsp.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `LLTD_ASSERT(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `LLTD_ASSERT(a_busy_ready, clk, rst_n, (state_reg != S_IDLE) |-> !in_req.ready, "ready while busy")
    `LLTD_ASSERT(a_out_hold, clk, rst_n, (out_rsp.valid && !out_rsp.ready) |=> $stable(rsp_reg), "result changed while stalled")
endmodule
